// File: hdl/rtlpm_pkg.sv
package rtlpm_pkg;

    // Table sizing and queue depth
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int IFACE_W  = 4;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;
    localparam int REQ_W    = 2;
    localparam int LEN_W    = 6;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOROUTE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_LOOKUP,
        OP_CLEAR,
        OP_RSVD
    } op_t;

    // Classified command passed from front to back
    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  lookup_addr;
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [IFACE_W-1:0] iface;
        logic [LEN_W-1:0]   mask_len;
    } cmd_t;

    // One stored table entry
    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [IFACE_W-1:0] iface;
        logic [LEN_W-1:0]   mask_len;
    } entry_t;

    // Count one bits: per-nibble counts, then a short sum of eight nibbles
    function automatic logic [LEN_W-1:0] ones_in(input logic [ADDR_W-1:0] v);
        logic [2:0]       nib [ADDR_W/4];
        logic [LEN_W-1:0] sum;
        sum = '0;
        for (int n = 0; n < ADDR_W / 4; n++)
        begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        for (int n = 0; n < ADDR_W / 4; n++)
        begin
            sum = sum + LEN_W'(nib[n]);
        end
        return sum;
    endfunction

endpackage

// File: hdl/route_table_longest_prefix_top.sv
// IPv4 routing table with longest-prefix-match lookup.
// Input channel (in_valid/in_ready) takes one request item: add an entry,
// look up an address, or clear the table. Every item yields exactly one
// result item on the output channel (out_valid/out_ready), in order.
// Items are classified on entry (mask length is counted here) and wait in a
// two-item queue; the back end executes them against a one-read, one-write table RAM.
// Add, clear and reserved items are handled from the idle state: the result is
// offered in the cycle after the back end takes the item, one item per cycle
// while the output is not stalled. A lookup reads the stored entries one per cycle
// through the table RAM read port, then passes the drain and finish states; on an
// empty table it goes straight to the finish state.
// The best match is the matching entry with the longest mask, earliest slot on
// a tie; a default route (destination zero) is used only when nothing else
// matches, the last one stored winning.
// Reset empties the table and the queue; entry contents are left as they are
// and are never read before being written again.
// When the receiver stalls the result stays in the output register, the back
// end holds its next result, and the queue keeps taking items until full.
module route_table_longest_prefix_top #(
    parameter int TABLE_DEPTH = rtlpm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rtlpm_pkg::REQ_W-1:0]     req_type,
    input  logic [rtlpm_pkg::ADDR_W-1:0]    lookup_addr,
    input  logic [rtlpm_pkg::ADDR_W-1:0]    route_dest,
    input  logic [rtlpm_pkg::ADDR_W-1:0]    route_mask,
    input  logic [rtlpm_pkg::ADDR_W-1:0]    route_gateway,
    input  logic [rtlpm_pkg::IFACE_W-1:0]   route_iface,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rtlpm_pkg::STATUS_W-1:0]  status,
    output logic [rtlpm_pkg::ADDR_W-1:0]    next_hop,
    output logic [rtlpm_pkg::IFACE_W-1:0]   out_iface,
    output logic [rtlpm_pkg::SLOT_W-1:0]    hit_slot,
    output logic                            used_default
);
    import rtlpm_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // Accept and classify items
    rtlpm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .lookup_addr   (lookup_addr),
        .route_dest    (route_dest),
        .route_mask    (route_mask),
        .route_gateway (route_gateway),
        .route_iface   (route_iface),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    // Execute items against the table
    rtlpm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .next_hop     (next_hop),
        .out_iface    (out_iface),
        .hit_slot     (hit_slot),
        .used_default (used_default)
    );

endmodule

// File: hdl/rtlpm_ram.sv
module rtlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/rtlpm_front.sv
module rtlpm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rtlpm_pkg::REQ_W-1:0]    req_type,
    input  logic [rtlpm_pkg::ADDR_W-1:0]   lookup_addr,
    input  logic [rtlpm_pkg::ADDR_W-1:0]   route_dest,
    input  logic [rtlpm_pkg::ADDR_W-1:0]   route_mask,
    input  logic [rtlpm_pkg::ADDR_W-1:0]   route_gateway,
    input  logic [rtlpm_pkg::IFACE_W-1:0]  route_iface,
    output logic                           q_valid,
    output rtlpm_pkg::cmd_t                q_cmd,
    input  logic                           q_pop
);
    import rtlpm_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              cmd_in;
    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push, pop;

    // Classify the request and precompute the prefix length of the mask
    always_comb
    begin
        cmd_in.lookup_addr = lookup_addr;
        cmd_in.dest        = route_dest;
        cmd_in.mask        = route_mask;
        cmd_in.gateway     = route_gateway;
        cmd_in.iface       = route_iface;
        cmd_in.mask_len    = ones_in(route_mask);
        unique case (req_type)
            REQ_ADD:    cmd_in.op = OP_ADD;
            REQ_LOOKUP: cmd_in.op = OP_LOOKUP;
            REQ_CLEAR:  cmd_in.op = OP_CLEAR;
            default:    cmd_in.op = OP_RSVD;
        endcase
    end

    assign in_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (fill_reg != '0);
    assign q_cmd    = queue_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> fill_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("queue fill did not grow on push");

endmodule

// File: hdl/rtlpm_back.sv
module rtlpm_back #(
    parameter int TABLE_DEPTH = rtlpm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  rtlpm_pkg::cmd_t                 q_cmd,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rtlpm_pkg::STATUS_W-1:0]  status,
    output logic [rtlpm_pkg::ADDR_W-1:0]    next_hop,
    output logic [rtlpm_pkg::IFACE_W-1:0]   out_iface,
    output logic [rtlpm_pkg::SLOT_W-1:0]    hit_slot,
    output logic                            used_default
);
    import rtlpm_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                have_best_reg, have_best_next;
    logic [LEN_W-1:0]    best_len_reg, best_len_next;
    logic [IDX_W-1:0]    best_slot_reg, best_slot_next;
    logic [ADDR_W-1:0]   best_gw_reg, best_gw_next;
    logic [IFACE_W-1:0]  best_if_reg, best_if_next;
    logic                have_dflt_reg, have_dflt_next;
    logic [IDX_W-1:0]    dflt_slot_reg, dflt_slot_next;
    logic [ADDR_W-1:0]   dflt_gw_reg, dflt_gw_next;
    logic [IFACE_W-1:0]  dflt_if_reg, dflt_if_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   next_hop_reg, next_hop_next;
    logic [IFACE_W-1:0]  out_iface_reg, out_iface_next;
    logic [SLOT_W-1:0]   hit_slot_reg, hit_slot_next;
    logic                used_default_reg, used_default_next;

    logic                out_free;
    logic                wr_en, rd_en;
    entry_t              wr_entry, rd_entry;
    logic [ENTRY_W-1:0]  rd_word;
    logic [IDX_W-1:0]    chosen_slot;
    logic [SLOT_W+IDX_W-1:0] chosen_ext, add_ext;

    // Table storage
    rtlpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (ENTRY_W'(wr_entry)),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_word)
    );

    assign rd_entry         = entry_t'(rd_word);
    assign wr_entry.dest     = q_cmd.dest;
    assign wr_entry.mask     = q_cmd.mask;
    assign wr_entry.gateway  = q_cmd.gateway;
    assign wr_entry.iface    = q_cmd.iface;
    assign wr_entry.mask_len = q_cmd.mask_len;

    assign out_free    = !out_valid_reg || out_ready;
    assign rd_en       = (state_reg == S_SCAN);
    assign chosen_slot = have_best_reg ? best_slot_reg : dflt_slot_reg;
    assign chosen_ext  = {{SLOT_W{1'b0}}, chosen_slot};
    assign add_ext     = {{SLOT_W{1'b0}}, count_reg[IDX_W-1:0]};

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        scan_idx_next     = scan_idx_reg;
        chk_valid_next    = 1'b0;
        chk_idx_next      = chk_idx_reg;
        addr_next         = addr_reg;
        have_best_next    = have_best_reg;
        best_len_next     = best_len_reg;
        best_slot_next    = best_slot_reg;
        best_gw_next      = best_gw_reg;
        best_if_next      = best_if_reg;
        have_dflt_next    = have_dflt_reg;
        dflt_slot_next    = dflt_slot_reg;
        dflt_gw_next      = dflt_gw_reg;
        dflt_if_next      = dflt_if_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        next_hop_next     = next_hop_reg;
        out_iface_next    = out_iface_reg;
        hit_slot_next     = hit_slot_reg;
        used_default_next = used_default_reg;
        q_pop             = 1'b0;
        wr_en             = 1'b0;

        // Judge the entry read last cycle; later default wins, longer mask wins
        if (chk_valid_reg)
        begin
            if (rd_entry.dest == '0)
            begin
                have_dflt_next = 1'b1;
                dflt_slot_next = chk_idx_reg;
                dflt_gw_next   = rd_entry.gateway;
                dflt_if_next   = rd_entry.iface;
            end
            else if (((rd_entry.dest & rd_entry.mask) == (addr_reg & rd_entry.mask)) &&
                     (!have_best_reg || rd_entry.mask_len > best_len_reg))
            begin
                have_best_next = 1'b1;
                best_len_next  = rd_entry.mask_len;
                best_slot_next = chk_idx_reg;
                best_gw_next   = rd_entry.gateway;
                best_if_next   = rd_entry.iface;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.op == OP_LOOKUP)
                    begin
                        // Start a scan over the stored entries
                        q_pop          = 1'b1;
                        addr_next      = q_cmd.lookup_addr;
                        have_best_next = 1'b0;
                        have_dflt_next = 1'b0;
                        scan_idx_next  = '0;
                        state_next     = (count_reg == '0) ? S_FINISH : S_SCAN;
                    end
                    else if (out_free)
                    begin
                        q_pop             = 1'b1;
                        out_valid_next    = 1'b1;
                        next_hop_next     = '0;
                        out_iface_next    = '0;
                        hit_slot_next     = '0;
                        used_default_next = 1'b0;
                        unique case (q_cmd.op)
                            OP_ADD:
                            begin
                                if (count_reg < CNT_W'(TABLE_DEPTH))
                                begin
                                    wr_en         = 1'b1;
                                    count_next    = count_reg + CNT_W'(1);
                                    status_next   = ST_ADDED;
                                    hit_slot_next = add_ext[SLOT_W-1:0];
                                end
                                else
                                begin
                                    status_next = ST_FULL;
                                end
                            end
                            OP_CLEAR:
                            begin
                                count_next  = '0;
                                status_next = ST_CLEARED;
                            end
                            default:
                            begin
                                status_next = ST_NOROUTE;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one table read per cycle
                chk_valid_next = 1'b1;
                chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                scan_idx_next  = scan_idx_reg + CNT_W'(1);
                if (scan_idx_reg == count_reg - CNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Report the chosen entry once the output slot is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (have_best_reg || have_dflt_reg)
                    begin
                        status_next       = ST_FOUND;
                        next_hop_next     = have_best_reg ? best_gw_reg : dflt_gw_reg;
                        out_iface_next    = have_best_reg ? best_if_reg : dflt_if_reg;
                        hit_slot_next     = chosen_ext[SLOT_W-1:0];
                        used_default_next = !have_best_reg;
                    end
                    else
                    begin
                        status_next       = ST_NOROUTE;
                        next_hop_next     = '0;
                        out_iface_next    = '0;
                        hit_slot_next     = '0;
                        used_default_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            scan_idx_reg     <= '0;
            chk_valid_reg    <= 1'b0;
            chk_idx_reg      <= '0;
            addr_reg         <= '0;
            have_best_reg    <= 1'b0;
            best_len_reg     <= '0;
            best_slot_reg    <= '0;
            best_gw_reg      <= '0;
            best_if_reg      <= '0;
            have_dflt_reg    <= 1'b0;
            dflt_slot_reg    <= '0;
            dflt_gw_reg      <= '0;
            dflt_if_reg      <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            next_hop_reg     <= '0;
            out_iface_reg    <= '0;
            hit_slot_reg     <= '0;
            used_default_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            scan_idx_reg     <= scan_idx_next;
            chk_valid_reg    <= chk_valid_next;
            chk_idx_reg      <= chk_idx_next;
            addr_reg         <= addr_next;
            have_best_reg    <= have_best_next;
            best_len_reg     <= best_len_next;
            best_slot_reg    <= best_slot_next;
            best_gw_reg      <= best_gw_next;
            best_if_reg      <= best_if_next;
            have_dflt_reg    <= have_dflt_next;
            dflt_slot_reg    <= dflt_slot_next;
            dflt_gw_reg      <= dflt_gw_next;
            dflt_if_reg      <= dflt_if_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            next_hop_reg     <= next_hop_next;
            out_iface_reg    <= out_iface_next;
            hit_slot_reg     <= hit_slot_next;
            used_default_reg <= used_default_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign next_hop     = next_hop_reg;
    assign out_iface    = out_iface_reg;
    assign hit_slot     = hit_slot_reg;
    assign used_default = used_default_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg < count_reg)
        else $error("scan index beyond stored entries");

    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("entry check outside of scan");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_FOUND) |->
            (next_hop_reg == '0 && used_default_reg == 1'b0))
        else $error("non-hit result carries route data");

endmodule
